### sv/srlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srlp_pkg
// Shared types, character codes and decode helpers of the S-record line parser.
// ----------------------------------------------------------------------------
package srlp_pkg;

  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_F = 8'h46;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_F = 8'h66;

  localparam logic [3:0] TYPE_HEADER   = 4'd0;
  localparam logic [3:0] TYPE_DATA_MIN = 4'd1;
  localparam logic [3:0] TYPE_DATA_MAX = 4'd3;
  localparam logic [3:0] TYPE_FIN_MIN  = 4'd7;
  localparam logic [3:0] TYPE_FIN_MAX  = 4'd9;
  localparam logic [3:0] TYPE_OTHER    = 4'hF;

  localparam int unsigned CharW = 8;
  localparam int unsigned OutW  = 64;

  typedef enum logic [1:0] {
    EV_DATA,
    EV_END,
    EV_BAD
  } event_e;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_DATA,
    KIND_FINAL,
    KIND_OTHER
  } kind_e;

  typedef struct packed {
    logic [7:0]  checksum_byte;
    logic [7:0]  byte_count;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    kind_e       record_kind;
    event_e      event_res;
  } result_t;

  // Bit 4 set marks a character that is not a hex digit.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    if (c >= CH_0 && c <= CH_9) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  function automatic kind_e kind_of(logic [3:0] t);
    kind_e k;
    if (t == TYPE_HEADER) begin
      k = KIND_HEADER;
    end else if (t >= TYPE_DATA_MIN && t <= TYPE_DATA_MAX) begin
      k = KIND_DATA;
    end else if (t >= TYPE_FIN_MIN && t <= TYPE_FIN_MAX) begin
      k = KIND_FINAL;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

### sv/srlp_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srlp_in_stage
// Input register that holds one character until the parser core takes it.
// ----------------------------------------------------------------------------
module srlp_in_stage (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_valid_i,
  output logic                           s_ready_o,
  input  wire logic [srlp_pkg::CharW-1:0] s_char_i,
  output logic                           valid_o,
  output logic [srlp_pkg::CharW-1:0]     char_o,
  input  wire logic                      take_i
);
  import srlp_pkg::*;

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q, char_d;

  assign s_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    char_d  = char_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
      char_d  = s_char_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      char_q  <= '0;
    end else begin
      valid_q <= valid_d;
      char_q  <= char_d;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;

  property p_take_needs_valid;
    @(posedge clk_i) disable iff (!rst_ni) take_i |-> valid_q;
  endproperty
  a_take_needs_valid: assert property (p_take_needs_valid)
    else $error("parser took a character from an empty input register");

  property p_held_when_not_taken;
    @(posedge clk_i) disable iff (!rst_ni) valid_q && !take_i |=> valid_q && $stable(char_q);
  endproperty
  a_held_when_not_taken: assert property (p_held_when_not_taken)
    else $error("input register lost a character that was not taken");

  property p_load_on_transfer;
    @(posedge clk_i) disable iff (!rst_ni)
      s_valid_i && s_ready_o |=> valid_q && char_q == $past(s_char_i);
  endproperty
  a_load_on_transfer: assert property (p_load_on_transfer)
    else $error("input register did not capture the transferred character");

endmodule
`default_nettype wire

### sv/srlp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srlp_core
// Record parser state machine with its result register.
// ----------------------------------------------------------------------------
module srlp_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [srlp_pkg::CharW-1:0] in_char_i,
  output logic                            take_o,
  output logic                            out_valid_o,
  output srlp_pkg::result_t               out_res_o,
  input  wire logic                       out_ready_i
);
  import srlp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_COUNT,
    PH_ADDR,
    PH_DATA,
    PH_CKSUM
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  type_q, type_d;
  logic [7:0]  count_q, count_d;
  logic [31:0] base_q, base_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  digits_q, digits_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  index_q, index_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;

  logic        step;
  logic        fire;
  result_t     res;
  logic [4:0]  hexv;
  logic        is_s;
  logic [31:0] acc_shift;
  logic [3:0]  digits_dec;
  kind_e       kind;
  logic [7:0]  cnt;

  assign step       = in_valid_i && (!out_valid_q || out_ready_i);
  assign take_o     = step;
  assign hexv       = hex_value(in_char_i);
  assign is_s       = (in_char_i == CH_S);
  assign acc_shift  = {acc_q[27:0], hexv[3:0]};
  assign digits_dec = (digits_q != 4'd0) ? digits_q - 4'd1 : digits_q;
  assign kind       = kind_of(type_q);
  assign cnt        = acc_shift[7:0];

  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    count_d  = count_q;
    base_d   = base_q;
    acc_d    = acc_q;
    digits_d = digits_q;
    left_d   = left_q;
    index_d  = index_q;
    fire     = 1'b0;
    res.event_res     = EV_BAD;
    res.record_kind   = kind;
    res.byte_address  = '0;
    res.data_byte     = '0;
    res.byte_count    = count_q;
    res.checksum_byte = '0;

    case (phase_q)
      PH_IDLE: begin
        if (is_s) begin
          phase_d  = PH_TYPE;
          type_d   = '0;
          count_d  = '0;
          base_d   = '0;
          acc_d    = '0;
          digits_d = '0;
          left_d   = '0;
          index_d  = '0;
        end
      end
      PH_TYPE: begin
        type_d   = (in_char_i >= CH_0 && in_char_i <= CH_9) ? in_char_i[3:0] : TYPE_OTHER;
        phase_d  = PH_COUNT;
        digits_d = 4'd2;
        acc_d    = '0;
      end
      PH_COUNT, PH_ADDR, PH_DATA, PH_CKSUM: begin
        if (hexv[4]) begin
          fire          = 1'b1;
          res.event_res = EV_BAD;
          if (is_s) begin
            phase_d  = PH_TYPE;
            type_d   = '0;
            count_d  = '0;
            base_d   = '0;
            acc_d    = '0;
            digits_d = '0;
            left_d   = '0;
            index_d  = '0;
          end else begin
            phase_d = PH_IDLE;
          end
        end else begin
          acc_d    = acc_shift;
          digits_d = digits_dec;
          if (digits_dec == 4'd0) begin
            case (phase_q)
              PH_COUNT: begin
                count_d        = cnt;
                res.byte_count = cnt;
                if (kind != KIND_DATA) begin
                  fire          = 1'b1;
                  res.event_res = EV_END;
                  phase_d       = PH_IDLE;
                end else if (cnt < 8'(type_q) + 8'd2) begin
                  fire          = 1'b1;
                  res.event_res = EV_BAD;
                  phase_d       = PH_IDLE;
                end else begin
                  left_d   = cnt - 8'(type_q) - 8'd2;
                  digits_d = 4'((type_q + 4'd1) << 1);
                  acc_d    = '0;
                  phase_d  = PH_ADDR;
                end
              end
              PH_ADDR: begin
                base_d   = acc_shift;
                index_d  = '0;
                acc_d    = '0;
                digits_d = 4'd2;
                phase_d  = (left_q == 8'd0) ? PH_CKSUM : PH_DATA;
              end
              PH_DATA: begin
                fire             = 1'b1;
                res.event_res    = EV_DATA;
                res.byte_address = base_q + {24'd0, index_q};
                res.data_byte    = acc_shift[7:0];
                index_d          = index_q + 8'd1;
                left_d           = left_q - 8'd1;
                acc_d            = '0;
                digits_d         = 4'd2;
                if (left_q == 8'd1) begin
                  phase_d = PH_CKSUM;
                end
              end
              PH_CKSUM: begin
                fire              = 1'b1;
                res.event_res     = EV_END;
                res.byte_address  = base_q;
                res.checksum_byte = acc_shift[7:0];
                phase_d           = PH_IDLE;
              end
              default: begin
                phase_d = PH_IDLE;
              end
            endcase
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (step) begin
      out_valid_d = fire;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      type_q      <= '0;
      count_q     <= '0;
      base_q      <= '0;
      acc_q       <= '0;
      digits_q    <= '0;
      left_q      <= '0;
      index_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (step) begin
        phase_q  <= phase_d;
        type_q   <= type_d;
        count_q  <= count_d;
        base_q   <= base_d;
        acc_q    <= acc_d;
        digits_q <= digits_d;
        left_q   <= left_d;
        index_q  <= index_d;
      end
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  property p_data_event_kind;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && out_q.event_res == EV_DATA |-> out_q.record_kind == KIND_DATA;
  endproperty
  a_data_event_kind: assert property (p_data_event_kind)
    else $error("data byte reported for a record that is not a data record");

  property p_addr_phase_kind;
    @(posedge clk_i) disable iff (!rst_ni)
      phase_q == PH_ADDR || phase_q == PH_DATA |-> kind == KIND_DATA;
  endproperty
  a_addr_phase_kind: assert property (p_addr_phase_kind)
    else $error("address or data phase entered for a non-data record");

  property p_digit_range;
    @(posedge clk_i) disable iff (!rst_ni) digits_q <= 4'd8;
  endproperty
  a_digit_range: assert property (p_digit_range)
    else $error("digit counter exceeds the longest field");

  property p_nondata_end_clean;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && out_q.event_res == EV_END && out_q.record_kind != KIND_DATA
      |-> out_q.byte_address == 32'd0 && out_q.checksum_byte == 8'd0;
  endproperty
  a_nondata_end_clean: assert property (p_nondata_end_clean)
    else $error("non-data record end carries address or checksum");

endmodule
`default_nettype wire

### sv/srecord_line_parser_unit.sv
// A character transferred into the input register sits there until the core steps on
// it, which it does once its result register is free or being taken, and any result it
// causes is valid on the master side from that step on.
// Throughput: one character per cycle; a result held by a low m_axis_tready stalls the
// core, and once the input register is also full the slave side stalls too.
// Reset: rst_ni clears the parser to idle, waiting for 'S', with both registers empty.
`default_nettype none
// ----------------------------------------------------------------------------
// srecord_line_parser_unit
// Motorola S-record character parser with stream interfaces on both sides.
// ----------------------------------------------------------------------------
module srecord_line_parser_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // ascii_char [7:0]
  input  wire logic [srlp_pkg::CharW-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // event_res [1:0], record_kind [3:2], byte_address [35:4], data_byte [43:36],
  // byte_count [51:44], checksum_byte [59:52], zero [63:60]
  output logic [srlp_pkg::OutW-1:0]      m_axis_tdata
);
  import srlp_pkg::*;

  logic             in_valid;
  logic [CharW-1:0] in_char;
  logic             take;
  result_t          res;

  srlp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_char_i  (s_axis_tdata),
    .valid_o   (in_valid),
    .char_o    (in_char),
    .take_i    (take)
  );

  srlp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_char_i   (in_char),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {(OutW - $bits(result_t))'(0), res};

endmodule
`default_nettype wire

### tb/tb_srecord_line_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_srecord_line_parser_unit
// Self-checking testbench for the S-record character parser. A short table of
// hand-written records runs first. Random record text follows: mostly
// well-formed data, header and final records with random content, plus noise,
// undersized counts and records broken by stray characters. Every character
// transfer is run through a parser model kept in the testbench. Each result
// transfer is compared field by field with the oldest expected result. Both
// sides idle at random in the first two of three stages, not in the third.
// ----------------------------------------------------------------------------
module tb_srecord_line_parser_unit;
  import srlp_pkg::*;

  localparam int unsigned CharGoal   = 1400;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DirRows    = 28;

  typedef enum logic [2:0] {
    P_IDLE,
    P_TYPE,
    P_COUNT,
    P_ADDR,
    P_DATA,
    P_CKSUM
  } parse_phase_e;

  typedef struct {
    logic [7:0] ch;
    bit         fixed;
    result_t    want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  parse_phase_e ps_phase;
  logic [3:0]   ps_type;
  logic [7:0]   ps_count;
  logic [31:0]  ps_base;
  logic [31:0]  ps_acc;
  logic [3:0]   ps_digits;
  logic [7:0]   ps_left;
  logic [7:0]   ps_index;

  result_t     want_q[$];
  logic [7:0]  text_q[$];
  stim_row_t   dir_table[DirRows];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int unsigned sent_chars = 0;
  int unsigned data_recs = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;

  srecord_line_parser_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return {1'b0, 4'(c - CH_0)};
    if (c >= CH_UP_A && c <= CH_UP_F) return {1'b0, 4'(c - CH_UP_A + 8'd10)};
    if (c >= CH_LO_A && c <= CH_LO_F) return {1'b0, 4'(c - CH_LO_A + 8'd10)};
    return 5'h10;
  endfunction

  function automatic kind_e record_class(logic [3:0] t);
    case (t)
      4'd0: return KIND_HEADER;
      4'd1, 4'd2, 4'd3: return KIND_DATA;
      4'd7, 4'd8, 4'd9: return KIND_FINAL;
      default: return KIND_OTHER;
    endcase
  endfunction

  function automatic result_t tag_event(event_e ev);
    result_t r;
    r = '0;
    r.event_res   = ev;
    r.record_kind = record_class(ps_type);
    r.byte_count  = ps_count;
    return r;
  endfunction

  task automatic open_record();
    ps_phase  = P_TYPE;
    ps_type   = 4'd0;
    ps_count  = 8'd0;
    ps_base   = 32'd0;
    ps_acc    = 32'd0;
    ps_digits = 4'd0;
    ps_left   = 8'd0;
    ps_index  = 8'd0;
  endtask

  task automatic parse_char(input logic [7:0] c, output bit hit, output result_t res);
    logic [4:0] nib;
    logic [7:0] alen;
    hit = 1'b0;
    res = '0;
    nib = nibble_of(c);
    case (ps_phase)
      P_IDLE: begin
        if (c == CH_S) open_record();
      end
      P_TYPE: begin
        ps_type   = (c >= CH_0 && c <= CH_9) ? c[3:0] : TYPE_OTHER;
        ps_phase  = P_COUNT;
        ps_digits = 4'd2;
        ps_acc    = 32'd0;
      end
      default: begin
        if (nib[4]) begin
          hit = 1'b1;
          res = tag_event(EV_BAD);
          if (c == CH_S) open_record();
          else ps_phase = P_IDLE;
        end else begin
          ps_acc = {ps_acc[27:0], nib[3:0]};
          if (ps_digits != 4'd0) ps_digits = ps_digits - 4'd1;
          if (ps_digits == 4'd0) begin
            case (ps_phase)
              P_COUNT: begin
                ps_count = ps_acc[7:0];
                alen = {4'd0, ps_type} + 8'd1;
                if (record_class(ps_type) != KIND_DATA) begin
                  hit = 1'b1;
                  res = tag_event(EV_END);
                  ps_phase = P_IDLE;
                end else if (ps_count < alen + 8'd1) begin
                  hit = 1'b1;
                  res = tag_event(EV_BAD);
                  ps_phase = P_IDLE;
                end else begin
                  ps_left   = ps_count - alen - 8'd1;
                  ps_digits = 4'(2 * alen);
                  ps_acc    = 32'd0;
                  ps_phase  = P_ADDR;
                end
              end
              P_ADDR: begin
                ps_base   = ps_acc;
                ps_index  = 8'd0;
                ps_acc    = 32'd0;
                ps_digits = 4'd2;
                ps_phase  = (ps_left == 8'd0) ? P_CKSUM : P_DATA;
              end
              P_DATA: begin
                hit = 1'b1;
                res = tag_event(EV_DATA);
                res.byte_address = ps_base + {24'd0, ps_index};
                res.data_byte    = ps_acc[7:0];
                ps_index  = ps_index + 8'd1;
                ps_left   = ps_left - 8'd1;
                ps_acc    = 32'd0;
                ps_digits = 4'd2;
                if (ps_left == 8'd0) ps_phase = P_CKSUM;
              end
              default: begin
                hit = 1'b1;
                res = tag_event(EV_END);
                res.byte_address  = ps_base;
                res.checksum_byte = ps_acc[7:0];
                ps_phase = P_IDLE;
              end
            endcase
          end
        end
      end
    endcase
  endtask

  function automatic stim_row_t plain_row(logic [7:0] c);
    stim_row_t r;
    r.ch    = c;
    r.fixed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [7:0] c, event_e ev, kind_e k,
                                          logic [31:0] a, logic [7:0] d,
                                          logic [7:0] n, logic [7:0] s);
    stim_row_t r;
    r.ch    = c;
    r.fixed = 1'b1;
    r.want  = '{checksum_byte: s, byte_count: n, data_byte: d, byte_address: a,
                record_kind: k, event_res: ev};
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return CH_0 + 8'(v);
    return (($urandom_range(1) != 0) ? CH_UP_A : CH_LO_A) + 8'(v) - 8'd10;
  endfunction

  task automatic add_hex(input logic [31:0] v, input int unsigned n);
    for (int i = n; i > 0; i--) text_q.push_back(hex_char(v[4*i-1 -: 4]));
  endtask

  task automatic gen_record();
    int unsigned pick;
    int unsigned alen;
    int unsigned nbytes;
    int unsigned first;
    int unsigned k;
    logic [7:0]  tch;
    logic [7:0]  bad;
    logic [4:0]  bad_nib;
    logic [31:0] addr;
    text_q.delete();
    if ($urandom_range(99) < 25) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
    end
    first = text_q.size();
    pick = $urandom_range(99);
    if (pick < 70) tch = CH_0 + 8'($urandom_range(1, 3));
    else if (pick < 78) tch = CH_0;
    else if (pick < 88) tch = CH_0 + 8'($urandom_range(7, 9));
    else tch = 8'($urandom_range(255));
    text_q.push_back(CH_S);
    text_q.push_back(tch);
    if (tch >= CH_0 + 8'd1 && tch <= CH_0 + 8'd3) begin
      alen = int'(tch - CH_0) + 1;
      pick = $urandom_range(99);
      if (pick < 8) begin
        add_hex($urandom_range(alen), 2);
        add_hex($urandom, $urandom_range(6));
      end else begin
        data_recs++;
        nbytes = (data_recs == 12 || pick == 99) ? 254 - alen : $urandom_range(8);
        add_hex(alen + 1 + nbytes, 2);
        addr = $urandom;
        if ($urandom_range(4) == 0) addr = 32'hFFFF_FFFF - $urandom_range(3);
        add_hex(addr, 2 * alen);
        repeat (nbytes) add_hex($urandom, 2);
        add_hex($urandom, 2);
      end
    end else begin
      add_hex($urandom_range(255), 2);
      add_hex($urandom, $urandom_range(8));
    end
    if ($urandom_range(9) == 0) begin
      k = $urandom_range(first + 2, text_q.size() - 1);
      if ($urandom_range(2) == 0) begin
        bad = CH_S;
      end else begin
        do begin
          bad     = 8'($urandom_range(255));
          bad_nib = nibble_of(bad);
        end while (!bad_nib[4]);
      end
      text_q[k] = bad;
    end
    text_q.push_back(8'h0D);
    text_q.push_back(8'h0A);
  endtask

  task automatic push_char(input logic [7:0] c, input bit fixed, input result_t fixed_res);
    bit      hit;
    result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_char(c, hit, res);
    sent_chars++;
    if (fixed) want_q.push_back(fixed_res);
    else if (hit) want_q.push_back(res);
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatches < 100) $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp_v);
    if (got !== exp_v) note_mismatch($sformatf("%s got %h, expected %h", name, got, exp_v));
  endtask

  task automatic compare_result(input logic [63:0] bus);
    result_t got;
    result_t want;
    got = result_t'(bus[59:0]);
    if (want_q.size() == 0) begin
      note_mismatch($sformatf("result transfer %h with nothing expected", bus));
      return;
    end
    want = want_q.pop_front();
    check_field("event_res", 32'(got.event_res), 32'(want.event_res));
    check_field("record_kind", 32'(got.record_kind), 32'(want.record_kind));
    check_field("byte_address", got.byte_address, want.byte_address);
    check_field("data_byte", 32'(got.data_byte), 32'(want.data_byte));
    check_field("byte_count", 32'(got.byte_count), 32'(want.byte_count));
    check_field("checksum_byte", 32'(got.checksum_byte), 32'(want.checksum_byte));
    check_field("padding", 32'(bus[63:60]), 32'd0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      if (m_axis_tvalid && m_axis_tready) compare_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[srecord_line_parser_unit] ERROR");
      $finish;
    end
  end

  initial begin
    dir_table = '{
      plain_row(8'hFF), plain_row(8'h00),
      plain_row("S"), plain_row("0"), plain_row("0"),
      known_row("3", EV_END, KIND_HEADER, 32'h0, 8'h00, 8'h03, 8'h00),
      plain_row("S"), plain_row("1"), plain_row("0"), plain_row("4"),
      plain_row("F"), plain_row("F"), plain_row("f"), plain_row("F"),
      plain_row("a"),
      known_row("b", EV_DATA, KIND_DATA, 32'h0000_FFFF, 8'hAB, 8'h04, 8'h00),
      plain_row("c"),
      known_row("D", EV_END, KIND_DATA, 32'h0000_FFFF, 8'h00, 8'h04, 8'hCD),
      plain_row("S"), plain_row("3"), plain_row("0"),
      known_row("3", EV_BAD, KIND_DATA, 32'h0, 8'h00, 8'h03, 8'h00),
      plain_row("S"), plain_row("9"),
      known_row("S", EV_BAD, KIND_FINAL, 32'h0, 8'h00, 8'h00, 8'h00),
      plain_row("Z"), plain_row("0"),
      known_row("0", EV_END, KIND_OTHER, 32'h0, 8'h00, 8'h00, 8'h00)
    };
    open_record();
    ps_phase = P_IDLE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 12;
    snk_idle_pct = 53;
    foreach (dir_table[i]) push_char(dir_table[i].ch, dir_table[i].fixed, dir_table[i].want);

    for (int stage = 0; stage < 3; stage++) begin
      if (stage != 0) begin
        // Hold the sender off until the parser has delivered everything.
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (want_q.size() != 0);
        src_idle_pct = (stage == 1) ? 53 : 0;
        snk_idle_pct = (stage == 1) ? 12 : 0;
      end
      while (sent_chars < CharGoal * (stage + 1) / 3) begin
        gen_record();
        foreach (text_q[i]) push_char(text_q[i], 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (want_q.size() != 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[srecord_line_parser_unit] OK");
    end else begin
      $display("[srecord_line_parser_unit] ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/srlp_pkg.sv
sv/srlp_in_stage.sv
sv/srlp_core.sv
sv/srecord_line_parser_unit.sv
tb/tb_srecord_line_parser_unit.sv
